// ===== rtl/core/frustum_sphere_cull_unit_assert.svh =====
// ----------------------------------------------------------------------------
// Frustum sphere cull unit assertion macros
// Shared concurrent assertion forms, clocked on clk_i and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef FRUSTUM_SPHERE_CULL_UNIT_ASSERT_SVH
`define FRUSTUM_SPHERE_CULL_UNIT_ASSERT_SVH

// Same-cycle implication.
`define FSC_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication.
`define FSC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/core/fsc_pkg.sv =====
// ----------------------------------------------------------------------------
// Frustum sphere cull package
// Shared constants, controller states and controller to datapath signals.
// ----------------------------------------------------------------------------
package fsc_pkg;

  localparam int FSC_COORD_WIDTH = 32;
  localparam int FSC_FRAC_BITS   = 16;
  localparam int IN_WIDTH        = 32;
  localparam int RADIUS_WIDTH    = 31;
  localparam int NUM_PLANES      = 6;
  localparam int PLANE_IDX_W     = 3;

  localparam logic       ACT_LOAD = 1'b0;
  localparam logic       ACT_TEST = 1'b1;
  localparam logic [1:0] LAST_COL = 2'd3;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_TEST,
    ST_TDRAIN,
    ST_EMIT,
    ST_DW,
    ST_DSQ,
    ST_DSQRT,
    ST_DDIVI,
    ST_DDIV,
    ST_DDIVW
  } fsc_state_e;

  typedef struct packed {
    logic                   load_go;
    logic                   test_go;
    logic [PLANE_IDX_W-1:0] p;
    logic [1:0]             k;
    logic                   mul_en;
    logic                   acc_en;
    logic                   emit;
    logic                   w_en;
    logic                   sq_clr;
    logic                   sq_en;
    logic                   sqrt_en;
    logic                   div_init;
    logic                   div_en;
    logic                   plane_wr;
  } fsc_cmd_t;

  typedef struct packed {
    logic mag_zero;
  } fsc_sts_t;

endpackage

// ===== rtl/core/frustum_sphere_cull_unit.sv =====
// ----------------------------------------------------------------------------
// Frustum sphere cull unit
// Six-plane view frustum test of bounding spheres in signed fixed point.
// ----------------------------------------------------------------------------
// A request either loads one column of the view-projection matrix or tests one
// sphere. Loading column 3 derives the left, right, bottom, top, near and far
// planes from the stored matrix and normalises each by the length of its
// normal, so columns 0 to 2 must be loaded first. A sphere request returns one
// visible flag; a column load returns nothing. After reset all planes are zero
// and every sphere is visible. A sphere test runs one plane per cycle through
// three parallel multipliers, then a compare stage and the output register;
// the result waits while the output is stalled. A column 3 load keeps the
// input stalled for the derivation, which for each plane runs a bit-serial
// square root and a bit-serial divider. The output register holds one result,
// so a new request is accepted while a previous flag still waits.
// ----------------------------------------------------------------------------
module frustum_sphere_cull_unit
  import fsc_pkg::*;
#(
  parameter int COORD_WIDTH = FSC_COORD_WIDTH,
  parameter int FRAC_BITS   = FSC_FRAC_BITS
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic                        action_i,
  input  logic [1:0]                  column_index_i,
  input  logic signed [IN_WIDTH-1:0]  elem_row0_i,
  input  logic signed [IN_WIDTH-1:0]  elem_row1_i,
  input  logic signed [IN_WIDTH-1:0]  elem_row2_i,
  input  logic signed [IN_WIDTH-1:0]  elem_row3_i,
  input  logic signed [IN_WIDTH-1:0]  center_x_i,
  input  logic signed [IN_WIDTH-1:0]  center_y_i,
  input  logic signed [IN_WIDTH-1:0]  center_z_i,
  input  logic [RADIUS_WIDTH-1:0]     radius_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic                        visible_o
);

  // The controller issues one command word per cycle; the datapath reports
  // only whether the current normal has zero length.
  fsc_cmd_t cmd;
  fsc_sts_t sts;

  fsc_ctrl #(
    .COORD_WIDTH(COORD_WIDTH),
    .FRAC_BITS  (FRAC_BITS)
  ) u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .action_i      (action_i),
    .column_index_i(column_index_i),
    .out_stall_i   (out_stall_i),
    .in_stall_o    (in_stall_o),
    .out_valid_o   (out_valid_o),
    .cmd_o         (cmd),
    .sts_i         (sts)
  );

  // Plane words are Q-format with FRAC_BITS fractional bits in COORD_WIDTH.
  fsc_dpath #(
    .COORD_WIDTH(COORD_WIDTH),
    .FRAC_BITS  (FRAC_BITS)
  ) u_dpath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .elem_row0_i   (elem_row0_i),
    .elem_row1_i   (elem_row1_i),
    .elem_row2_i   (elem_row2_i),
    .elem_row3_i   (elem_row3_i),
    .column_index_i(column_index_i),
    .center_x_i    (center_x_i),
    .center_y_i    (center_y_i),
    .center_z_i    (center_z_i),
    .radius_i      (radius_i),
    .visible_o     (visible_o)
  );

endmodule

// ===== rtl/core/fsc_ctrl.sv =====
// ----------------------------------------------------------------------------
// Frustum sphere cull controller
// Sequences sphere tests and plane derivation, and owns both handshakes.
// ----------------------------------------------------------------------------
`include "frustum_sphere_cull_unit_assert.svh"

module fsc_ctrl
  import fsc_pkg::*;
#(
  parameter int COORD_WIDTH = FSC_COORD_WIDTH,
  parameter int FRAC_BITS   = FSC_FRAC_BITS
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  input  logic       action_i,
  input  logic [1:0] column_index_i,
  input  logic       out_stall_i,
  output logic       in_stall_o,
  output logic       out_valid_o,
  output fsc_cmd_t   cmd_o,
  input  fsc_sts_t   sts_i
);

  localparam int NW = COORD_WIDTH + FRAC_BITS;
  localparam int CW = $clog2(NW + 1);

  fsc_state_e             state_q, state_d;
  logic [PLANE_IDX_W-1:0] p_q, p_d;
  logic [1:0]             k_q, k_d;
  logic [CW-1:0]          cnt_q, cnt_d;
  logic                   out_valid_q;
  logic                   accept;
  logic                   slot_free;

  assign accept    = in_valid_i && (state_q == ST_IDLE);
  assign slot_free = !out_valid_q || !out_stall_i;

  always_comb begin
    state_d = state_q;
    p_d     = p_q;
    k_d     = k_q;
    cnt_d   = cnt_q;
    case (state_q)
      ST_IDLE: begin
        if (accept && action_i == ACT_TEST) begin
          state_d = ST_TEST;
          p_d     = '0;
        end else if (accept && column_index_i == LAST_COL) begin
          state_d = ST_DW;
          p_d     = '0;
          k_d     = '0;
        end
      end
      ST_TEST: begin
        if (p_q == PLANE_IDX_W'(NUM_PLANES - 1)) begin
          state_d = ST_TDRAIN;
        end else begin
          p_d = p_q + 1'b1;
        end
      end
      ST_TDRAIN: state_d = ST_EMIT;
      ST_EMIT: begin
        if (slot_free) begin
          state_d = ST_IDLE;
        end
      end
      ST_DW: begin
        k_d = k_q + 1'b1;
        if (k_q == 2'd3) begin
          state_d = ST_DSQ;
        end
      end
      ST_DSQ: begin
        if (k_q == 2'd2) begin
          state_d = ST_DSQRT;
          k_d     = '0;
          cnt_d   = '0;
        end else begin
          k_d = k_q + 1'b1;
        end
      end
      ST_DSQRT: begin
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == CW'(COORD_WIDTH - 1)) begin
          state_d = ST_DDIVI;
        end
      end
      ST_DDIVI: begin
        cnt_d   = '0;
        state_d = sts_i.mag_zero ? ST_DDIVW : ST_DDIV;
      end
      ST_DDIV: begin
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == CW'(NW - 1)) begin
          state_d = ST_DDIVW;
        end
      end
      ST_DDIVW: begin
        k_d = k_q + 1'b1;
        if (k_q != 2'd3) begin
          state_d = ST_DDIVI;
        end else if (p_q == PLANE_IDX_W'(NUM_PLANES - 1)) begin
          state_d = ST_IDLE;
        end else begin
          state_d = ST_DW;
          p_d     = p_q + 1'b1;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o          = '0;
    cmd_o.p        = p_q;
    cmd_o.k        = k_q;
    cmd_o.load_go  = accept && action_i == ACT_LOAD;
    cmd_o.test_go  = accept && action_i == ACT_TEST;
    case (state_q)
      ST_TEST: begin
        cmd_o.mul_en = 1'b1;
        cmd_o.acc_en = (p_q != '0);
      end
      ST_TDRAIN: cmd_o.acc_en = 1'b1;
      ST_EMIT:   cmd_o.emit = slot_free;
      ST_DW: begin
        cmd_o.w_en   = 1'b1;
        cmd_o.sq_clr = (k_q == 2'd0);
      end
      ST_DSQ:   cmd_o.sq_en = 1'b1;
      ST_DSQRT: cmd_o.sqrt_en = 1'b1;
      ST_DDIVI: cmd_o.div_init = 1'b1;
      ST_DDIV:  cmd_o.div_en = 1'b1;
      ST_DDIVW: cmd_o.plane_wr = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      p_q         <= '0;
      k_q         <= '0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      p_q     <= p_d;
      k_q     <= k_d;
      cnt_q   <= cnt_d;
      if (cmd_o.emit) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign in_stall_o  = (state_q != ST_IDLE);
  assign out_valid_o = out_valid_q;

  `FSC_ASSERT_IMPL(a_emit_slot_free, cmd_o.emit, !out_valid_q || !out_stall_i, "emit into busy slot")
  `FSC_ASSERT_NEXT(a_test_start, cmd_o.test_go, state_q == ST_TEST && p_q == '0, "test not started")
  `FSC_ASSERT_NEXT(a_derive_start, cmd_o.load_go && column_index_i == LAST_COL, state_q == ST_DW && p_q == '0 && k_q == 2'd0, "derivation not started")
  `FSC_ASSERT_IMPL(a_sqrt_bound, state_q == ST_DSQRT, cnt_q < CW'(COORD_WIDTH), "root count overrun")

endmodule

// ===== rtl/core/fsc_dpath.sv =====
// ----------------------------------------------------------------------------
// Frustum sphere cull datapath
// Matrix and plane storage, plane test arithmetic, root and divider units.
// ----------------------------------------------------------------------------
module fsc_dpath
  import fsc_pkg::*;
#(
  parameter int COORD_WIDTH = FSC_COORD_WIDTH,
  parameter int FRAC_BITS   = FSC_FRAC_BITS
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  fsc_cmd_t                       cmd_i,
  output fsc_sts_t                       sts_o,
  input  logic signed [IN_WIDTH-1:0]     elem_row0_i,
  input  logic signed [IN_WIDTH-1:0]     elem_row1_i,
  input  logic signed [IN_WIDTH-1:0]     elem_row2_i,
  input  logic signed [IN_WIDTH-1:0]     elem_row3_i,
  input  logic [1:0]                     column_index_i,
  input  logic signed [IN_WIDTH-1:0]     center_x_i,
  input  logic signed [IN_WIDTH-1:0]     center_y_i,
  input  logic signed [IN_WIDTH-1:0]     center_z_i,
  input  logic [RADIUS_WIDTH-1:0]        radius_i,
  output logic                           visible_o
);

  localparam int W  = COORD_WIDTH;
  localparam int FB = FRAC_BITS;
  localparam int NW = W + FB;
  localparam int XW = ((NW > IN_WIDTH) ? NW : IN_WIDTH) + 2;
  localparam int AW = 2 * W + 2;
  localparam logic signed [XW-1:0] XMAX = {{(XW-W+1){1'b0}}, {(W-1){1'b1}}};
  localparam logic signed [XW-1:0] XMIN = {{(XW-W+1){1'b1}}, {(W-1){1'b0}}};

  function automatic logic signed [W-1:0] sat_x(input logic signed [XW-1:0] v);
    logic signed [W-1:0] r;
    if (v > XMAX) begin
      r = XMAX[W-1:0];
    end else if (v < XMIN) begin
      r = XMIN[W-1:0];
    end else begin
      r = v[W-1:0];
    end
    return r;
  endfunction

  function automatic logic [W-1:0] abs_w(input logic signed [W-1:0] v);
    return v[W-1] ? W'(-v) : W'(v);
  endfunction

  // Matrix: row w per column, rows x, y, z per column.
  logic signed [W-1:0]   roww_q [4];
  logic signed [W-1:0]   rowxyz_q [4][3];
  logic signed [W-1:0]   plane_q [NUM_PLANES][4];
  logic signed [W-1:0]   cx_q, cy_q, cz_q, pd_q;
  logic [RADIUS_WIDTH-1:0] rad_q;
  logic signed [2*W-1:0] pa_q, pb_q, pc_q;
  logic                  vis_acc_q, vis_q;
  logic signed [W-1:0]   wv_q [4];
  logic [2*W-1:0]        sq_q;
  logic [W+1:0]          rem_q;
  logic [W-1:0]          root_q;
  logic [NW-1:0]         num_q;
  logic [W-1:0]          drem_q;
  logic                  neg_q;

  logic signed [AW-1:0]  plane_sum;
  logic                  fail;
  logic signed [W-1:0]   rw, ra, wsum;
  logic [1:0]            axis;
  logic [W-1:0]          am;
  logic [W+1:0]          rem_n, trial;
  logic [W:0]            drem_n, ddiff;
  logic                  dge;
  logic signed [XW-1:0]  qx;
  logic signed [W-1:0]   wr_val;

  assign plane_sum = (AW'(pa_q) >>> FB) + (AW'(pb_q) >>> FB) + (AW'(pc_q) >>> FB)
                   + AW'(pd_q) + AW'($signed({1'b0, rad_q}));
  assign fail = plane_sum[AW-1];

  assign axis = cmd_i.p[2:1];
  assign rw   = roww_q[cmd_i.k];
  assign ra   = rowxyz_q[cmd_i.k][axis];
  assign wsum = cmd_i.p[0] ? sat_x(XW'(rw) - XW'(ra)) : sat_x(XW'(rw) + XW'(ra));
  assign am   = abs_w(wv_q[cmd_i.k]);

  // Digit-by-digit square root, two radicand bits per step.
  assign rem_n = {rem_q[W-1:0], sq_q[2*W-1:2*W-2]};
  assign trial = {root_q, 2'b01};

  // Restoring division, one quotient bit per step.
  assign drem_n = {drem_q, num_q[NW-1]};
  assign dge    = drem_n >= {1'b0, root_q};
  assign ddiff  = drem_n - {1'b0, root_q};

  assign qx     = neg_q ? -$signed(XW'(num_q)) : $signed(XW'(num_q));
  assign wr_val = sts_o.mag_zero ? wv_q[cmd_i.k] : sat_x(qx);

  assign sts_o.mag_zero = (root_q == '0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int p = 0; p < NUM_PLANES; p++) begin
        for (int k = 0; k < 4; k++) begin
          plane_q[p][k] <= '0;
        end
      end
    end else if (cmd_i.plane_wr) begin
      plane_q[cmd_i.p][cmd_i.k] <= wr_val;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_go) begin
      roww_q[column_index_i]      <= sat_x(XW'(elem_row3_i));
      rowxyz_q[column_index_i][0] <= sat_x(XW'(elem_row0_i));
      rowxyz_q[column_index_i][1] <= sat_x(XW'(elem_row1_i));
      rowxyz_q[column_index_i][2] <= sat_x(XW'(elem_row2_i));
    end
    if (cmd_i.test_go) begin
      cx_q      <= sat_x(XW'(center_x_i));
      cy_q      <= sat_x(XW'(center_y_i));
      cz_q      <= sat_x(XW'(center_z_i));
      rad_q     <= radius_i;
      vis_acc_q <= 1'b1;
    end else if (cmd_i.acc_en) begin
      vis_acc_q <= vis_acc_q & ~fail;
    end
    if (cmd_i.mul_en) begin
      pa_q <= plane_q[cmd_i.p][0] * cx_q;
      pb_q <= plane_q[cmd_i.p][1] * cy_q;
      pc_q <= plane_q[cmd_i.p][2] * cz_q;
      pd_q <= plane_q[cmd_i.p][3];
    end
    if (cmd_i.emit) begin
      vis_q <= vis_acc_q;
    end
    if (cmd_i.w_en) begin
      wv_q[cmd_i.k] <= wsum;
    end
    if (cmd_i.sq_clr) begin
      sq_q   <= '0;
      rem_q  <= '0;
      root_q <= '0;
    end else if (cmd_i.sq_en) begin
      sq_q <= sq_q + am * am;
    end else if (cmd_i.sqrt_en) begin
      sq_q <= {sq_q[2*W-3:0], 2'b00};
      if (rem_n >= trial) begin
        rem_q  <= rem_n - trial;
        root_q <= {root_q[W-2:0], 1'b1};
      end else begin
        rem_q  <= rem_n;
        root_q <= {root_q[W-2:0], 1'b0};
      end
    end
    if (cmd_i.div_init) begin
      neg_q  <= wv_q[cmd_i.k][W-1];
      num_q  <= {am, {FB{1'b0}}};
      drem_q <= '0;
    end else if (cmd_i.div_en) begin
      num_q  <= {num_q[NW-2:0], dge};
      drem_q <= dge ? ddiff[W-1:0] : drem_n[W-1:0];
    end
  end

  assign visible_o = vis_q;

endmodule
